// ----- design/serial_line_editor_with_echo_assert.svh -----
// Assertion macros for the serial line editor.
// Depends on nothing; expects clk and rst_n in the including module.
`ifndef SERIAL_LINE_EDITOR_WITH_ECHO_ASSERT_SVH
`define SERIAL_LINE_EDITOR_WITH_ECHO_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SLE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SLE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sle_pkg.sv -----
// Shared types and constants for the serial line editor.
// No dependencies.
package sle_pkg;

  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int LEN_W    = 6;

  // Action codes of an input item
  localparam logic [ACTION_W-1:0] ACT_RX   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INTR = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

  // Characters with special meaning
  localparam logic [BYTE_W-1:0] DEL_CHAR = 8'd127;
  localparam logic [BYTE_W-1:0] CR_CHAR  = 8'd13;
  localparam logic [BYTE_W-1:0] LF_CHAR  = 8'd10;

  // Which result of the held item goes out next
  typedef enum logic [1:0] {
    PH_FIRST,
    PH_CR,
    PH_LF
  } phase_t;

endpackage

// ----- design/sle_if.sv -----
// Valid/ready channel interfaces for the serial line editor.
// Depends on sle_pkg for field widths.
interface sle_in_if;
  import sle_pkg::*;

  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [BYTE_W-1:0]   rx_byte;
  logic [POS_W-1:0]    read_position;

  modport source (output valid, action, rx_byte, read_position, input ready);
  modport sink   (input valid, action, rx_byte, read_position, output ready);
endinterface

interface sle_out_if;
  import sle_pkg::*;

  logic              valid;
  logic              ready;
  logic              tx_valid;
  logic [BYTE_W-1:0] tx_byte;
  logic              line_done;
  logic              interrupted;
  logic [LEN_W-1:0]  line_length;
  logic [BYTE_W-1:0] read_data;
  logic              last;

  modport source (output valid, tx_valid, tx_byte, line_done, interrupted,
                  line_length, read_data, last, input ready);
  modport sink   (input valid, tx_valid, tx_byte, line_done, interrupted,
                  line_length, read_data, last, output ready);
endinterface

// ----- design/serial_line_editor_with_echo.sv -----
// Serial line editor with echo: builds one text line from received bytes.
// Accepted items are held in the issue stage, whose results pass to the output register.
// Throughput: one item per cycle for single-result items when the output does not stall;
//   a closing byte holds the issue stage until its echo, any added CR and the LF go out.
// Reset: synchronous, active low; clears fill count, closed flag and pipeline valids.
//   The line store is not cleared; read data is returned only for positions below the fill count.
`include "serial_line_editor_with_echo_assert.svh"

module serial_line_editor_with_echo #(
  parameter int LINE_BYTES = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  sle_in_if.sink    in_ch,
  sle_out_if.source out_ch
);
  import sle_pkg::*;

  // Fill count never exceeds LINE_BYTES-1, so this width holds it and addresses the store
  localparam int FW = $clog2(LINE_BYTES);
  // Common width for comparing the fill count with the read position and the length port
  localparam int PW = (FW > POS_W) ? FW : POS_W;

  // ---------------------------------------------------------------------------
  // Line state: fill count and closed flag live in flops, the bytes in a memory
  // ---------------------------------------------------------------------------
  logic [FW-1:0]     fill_r, fill_nxt;
  logic              closed_r, closed_nxt;
  logic [BYTE_W-1:0] line_mem [LINE_BYTES];
  logic [BYTE_W-1:0] rd_data_r;

  // Issue stage: one held item, emitting its results in order
  logic              s1_valid_r, s1_valid_nxt;
  phase_t            phase_r, phase_nxt;
  logic              s1_echo_v_r, s1_echo_v_nxt;
  logic [BYTE_W-1:0] s1_echo_b_r, s1_echo_b_nxt;
  logic              s1_intr_r, s1_intr_nxt;
  logic              s1_add_cr_r, s1_add_cr_nxt;
  logic              s1_add_lf_r, s1_add_lf_nxt;
  logic              s1_hit_r, s1_hit_nxt;
  logic [LEN_W-1:0]  s1_len_r, s1_len_nxt;

  // Output register
  logic              out_valid_r;
  logic              out_tx_valid_r;
  logic [BYTE_W-1:0] out_tx_byte_r;
  logic              out_done_r;
  logic              out_intr_r;
  logic [LEN_W-1:0]  out_len_r;
  logic [BYTE_W-1:0] out_rdata_r;
  logic              out_last_r;

  // Handshake
  logic in_fire, out_space, s1_emit, s1_final;

  // Current result of the issue stage
  logic              res_tx_valid;
  logic [BYTE_W-1:0] res_tx_byte;
  logic              res_done;
  logic              res_intr;
  logic [BYTE_W-1:0] res_rdata;

  // Accept-side decode
  logic [FW-1:0] base;
  logic [FW-1:0] base_inc;
  logic          is_full;
  logic          is_cr;
  logic          mem_wr;
  logic          mem_rd;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] fill_ext;
  logic [PW-1:0] len_ext;

  assign out_space = !out_valid_r || out_ch.ready;
  assign s1_emit   = s1_valid_r && out_space;
  assign in_ch.ready = !s1_valid_r || (out_space && s1_final);
  assign in_fire   = in_ch.valid && in_ch.ready;

  // A byte after close starts over on an empty line
  assign base     = closed_r ? '0 : fill_r;
  assign base_inc = base + FW'(1);
  assign is_full  = base_inc >= FW'(LINE_BYTES - 1);
  assign is_cr    = in_ch.rx_byte == CR_CHAR;
  assign pos_ext  = PW'(in_ch.read_position);
  assign fill_ext = PW'(fill_r);
  assign len_ext  = PW'(fill_nxt);

  assign mem_wr = in_fire && (in_ch.action == ACT_RX) && (in_ch.rx_byte != DEL_CHAR);
  assign mem_rd = in_fire && (in_ch.action == ACT_READ);

  // Decode the incoming item into the next line state and a result descriptor
  always_comb begin
    fill_nxt      = fill_r;
    closed_nxt    = closed_r;
    s1_echo_v_nxt = 1'b0;
    s1_echo_b_nxt = '0;
    s1_intr_nxt   = 1'b0;
    s1_add_cr_nxt = 1'b0;
    s1_add_lf_nxt = 1'b0;
    s1_hit_nxt    = 1'b0;
    if (in_fire) begin
      priority if (in_ch.action == ACT_RX) begin
        closed_nxt = 1'b0;
        if (in_ch.rx_byte != DEL_CHAR) begin
          s1_echo_v_nxt = 1'b1;
          s1_echo_b_nxt = in_ch.rx_byte;
          if (is_cr || is_full) begin
            // Close: strip a terminating CR, keep a byte that fills the line
            closed_nxt    = 1'b1;
            fill_nxt      = is_cr ? base : base_inc;
            s1_add_cr_nxt = is_full;
            s1_add_lf_nxt = 1'b1;
          end else begin
            fill_nxt = base_inc;
          end
        end else if (base != '0) begin
          // Delete the last byte and echo the DEL
          fill_nxt      = base - FW'(1);
          s1_echo_v_nxt = 1'b1;
          s1_echo_b_nxt = DEL_CHAR;
        end else begin
          fill_nxt = base;
        end
      end else if (in_ch.action == ACT_INTR) begin
        if (!closed_r) begin
          closed_nxt  = 1'b1;
          s1_intr_nxt = 1'b1;
        end
      end else if (in_ch.action == ACT_READ) begin
        s1_hit_nxt = pos_ext < fill_ext;
      end else begin
        // Unused action: one empty result
        s1_hit_nxt = 1'b0;
      end
    end
    s1_len_nxt = len_ext[LEN_W-1:0];
  end

  // Line store: write the new byte at the fill position, read for a read action
  always_ff @(posedge clk) begin
    if (mem_wr) begin
      line_mem[base] <= in_ch.rx_byte;
    end
    if (mem_rd) begin
      rd_data_r <= line_mem[pos_ext[FW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      closed_r <= 1'b0;
    end else if (in_fire) begin
      fill_r   <= fill_nxt;
      closed_r <= closed_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Issue stage: results of the held item, unless the output stalls, one per cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    res_tx_valid = 1'b0;
    res_tx_byte  = '0;
    res_done     = 1'b0;
    res_intr     = 1'b0;
    res_rdata    = '0;
    s1_final     = 1'b1;
    unique case (phase_r)
      PH_FIRST: begin
        res_tx_valid = s1_echo_v_r;
        res_tx_byte  = s1_echo_b_r;
        res_done     = s1_intr_r;
        res_intr     = s1_intr_r;
        res_rdata    = s1_hit_r ? rd_data_r : '0;
        s1_final     = !s1_add_lf_r;
      end
      PH_CR: begin
        res_tx_valid = 1'b1;
        res_tx_byte  = CR_CHAR;
        s1_final     = 1'b0;
      end
      PH_LF: begin
        res_tx_valid = 1'b1;
        res_tx_byte  = LF_CHAR;
        res_done     = 1'b1;
      end
      default: begin
        s1_final = 1'b1;
      end
    endcase
  end

  // Next phase and valid of the issue stage
  always_comb begin
    phase_nxt    = phase_r;
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      phase_nxt    = PH_FIRST;
      s1_valid_nxt = 1'b1;
    end else if (s1_emit) begin
      if (s1_final) begin
        s1_valid_nxt = 1'b0;
        phase_nxt    = PH_FIRST;
      end else begin
        unique case (phase_r)
          PH_FIRST: phase_nxt = s1_add_cr_r ? PH_CR : PH_LF;
          PH_CR:    phase_nxt = PH_LF;
          default:  phase_nxt = PH_FIRST;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_FIRST;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
    end
  end

  // Descriptor payload: hold until the next item is taken
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_echo_v_r <= s1_echo_v_nxt;
      s1_echo_b_r <= s1_echo_b_nxt;
      s1_intr_r   <= s1_intr_nxt;
      s1_add_cr_r <= s1_add_cr_nxt;
      s1_add_lf_r <= s1_add_lf_nxt;
      s1_hit_r    <= s1_hit_nxt;
      s1_len_r    <= s1_len_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: advance when empty or taken
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_emit) begin
      out_tx_valid_r <= res_tx_valid;
      out_tx_byte_r  <= res_tx_byte;
      out_done_r     <= res_done;
      out_intr_r     <= res_intr;
      out_len_r      <= s1_len_r;
      out_rdata_r    <= res_rdata;
      out_last_r     <= s1_final;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.tx_valid    = out_tx_valid_r;
  assign out_ch.tx_byte     = out_tx_byte_r;
  assign out_ch.line_done   = out_done_r;
  assign out_ch.interrupted = out_intr_r;
  assign out_ch.line_length = out_len_r;
  assign out_ch.read_data   = out_rdata_r;
  assign out_ch.last        = out_last_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `SLE_ASSERT_NEXT(a_fill_holds_idle, !in_fire, $stable(fill_r) && $stable(closed_r),
    "line state changed without an accepted item")
  `SLE_ASSERT_NOW(a_no_take_mid_item, s1_valid_r && !s1_final, !in_ch.ready,
    "input taken while the held item still has results")
  `SLE_ASSERT_NOW(a_lf_closes, out_valid_r && out_done_r && !out_intr_r,
    out_tx_byte_r == LF_CHAR && out_last_r, "line close not marked by final LF")
  `SLE_ASSERT_NOW(a_intr_silent, out_valid_r && out_intr_r,
    out_done_r && out_last_r && !out_tx_valid_r, "interrupt result malformed")

endmodule
